// File: rtl/spcs_pkg.sv
// Shared types and constants of the servo PPM chunk scheduler.
package spcs_pkg;

	localparam int IDX_W   = 5;
	localparam int TICK_W  = 16;
	localparam int CHAN_W  = 4;
	localparam int CMP_W   = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic CMD_MATCH = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SERVO_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 2'd1;

	localparam logic [TICK_W-1:0] MAX_PULSE_RST    = 16'd5500;
	localparam logic [TICK_W-1:0] CHUNK_LONG_LIMIT = 16'd384;
	localparam logic [TICK_W-1:0] CHUNK_MID_LIMIT  = 16'd256;
	localparam logic [TICK_W-1:0] CHUNK_LONG       = 16'd256;
	localparam logic [TICK_W-1:0] CHUNK_MID        = 16'd128;
	localparam logic [TICK_W-1:0] FRAME_SLACK      = 16'd128;
	localparam logic [CMP_W-1:0]  CMP_LONG         = 8'd255;
	localparam logic [CMP_W-1:0]  CMP_MID          = 8'd127;

	typedef struct packed {
		logic              wr_en;
		logic [IDX_W-1:0]  wr_idx;
		logic [TICK_W-1:0] wr_data;
		logic [IDX_W-1:0]  rd_idx;
	} tbl_req_t;

	typedef struct packed {
		logic [CMP_W-1:0] compare_value;
		logic             set_on_match;
		logic             counter_reset;
	} result_t;

endpackage

// File: rtl/spcs_if.sv
// Handshake channels of the servo PPM chunk scheduler.
interface spcs_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  channel;
	logic [15:0] pulse_ticks;
	modport source (output valid, cmd, channel, pulse_ticks, input ready);
	modport sink (input valid, cmd, channel, pulse_ticks, output ready);
endinterface

interface spcs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] compare_value;
	logic       set_on_match;
	logic       counter_reset;
	modport source (output valid, compare_value, set_on_match, counter_reset, input ready);
	modport sink (input valid, compare_value, set_on_match, counter_reset, output ready);
endinterface

interface spcs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/spcs_table.sv
// Channel pulse table: synchronous memory with valid bits and write-to-read forwarding.
module spcs_table import spcs_pkg::*; #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tbl_req_t          req,
	output logic [TICK_W-1:0] rd_data
);
	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [IDX_W:0] DEPTH = (IDX_W+1)'(MAX_CHANNELS);

	logic [TICK_W-1:0]       mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] valid_q;
	logic [TICK_W-1:0]       rd_data_q;
	logic                    rd_ok_q;
	logic                    wr_ok;
	logic                    rd_in;
	logic                    hit;
	logic [AW-1:0]           wa;
	logic [AW-1:0]           ra;

	assign wr_ok = req.wr_en && ({1'b0, req.wr_idx} < DEPTH);
	assign rd_in = {1'b0, req.rd_idx} < DEPTH;
	assign wa    = req.wr_idx[AW-1:0];
	assign ra    = req.rd_idx[AW-1:0];
	assign hit   = wr_ok && rd_in && (wa == ra);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wa] <= req.wr_data;
		end
		// forward a beat written to the entry being fetched
		rd_data_q <= hit ? req.wr_data : mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				valid_q[wa] <= 1'b1;
			end
			rd_ok_q <= rd_in && (valid_q[ra] || hit);
		end
	end

	assign rd_data = rd_ok_q ? rd_data_q : '0;

endmodule

// File: rtl/spcs_sched.sv
// Frame and chunk scheduling state, updated once per compare event.
module spcs_sched import spcs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              cmd,
	input  logic [CHAN_W-1:0] channel,
	input  logic [TICK_W-1:0] pulse_ticks,
	input  logic [IDX_W-1:0]  servo_count,
	input  logic [TICK_W-1:0] max_pulse_ticks,
	input  logic [TICK_W-1:0] next_pulse,
	output tbl_req_t          tbl_req,
	output result_t           res
);
	logic [TICK_W-1:0] rem_q, sum_q;
	logic [IDX_W-1:0]  idx_q;
	logic              mode_q, rline_q;

	logic [TICK_W-1:0] rem_ld, rem_n, sum_n;
	logic [IDX_W-1:0]  idx_n, idx_d;
	logic              mode_n, rline_n, ev;
	logic [TICK_W+IDX_W-1:0] frame_prod;
	logic [TICK_W-1:0] gap;

	assign ev         = fire && (cmd == CMD_MATCH);
	assign frame_prod = max_pulse_ticks * servo_count;
	assign gap        = frame_prod[TICK_W-1:0] + FRAME_SLACK - sum_q;

	always_comb begin
		rem_ld  = rem_q;
		sum_n   = sum_q;
		idx_n   = idx_q;
		rline_n = rline_q;
		mode_n  = mode_q;
		if (rem_q == '0) begin
			if (idx_q < servo_count) begin
				rem_ld = next_pulse;
				sum_n  = sum_q + next_pulse;
				idx_n  = idx_q + 1'b1;
			end else begin
				// end of frame: load the gap and restart the counter
				rem_ld  = gap;
				sum_n   = '0;
				idx_n   = '0;
				rline_n = 1'b1;
			end
		end
		res.compare_value = CMP_LONG;
		priority if (rem_ld > CHUNK_LONG_LIMIT) begin
			mode_n = 1'b0;
			rem_n  = rem_ld - CHUNK_LONG;
		end else if (rem_ld > CHUNK_MID_LIMIT) begin
			res.compare_value = CMP_MID;
			rem_n = rem_ld - CHUNK_MID;
		end else begin
			mode_n  = 1'b1;
			rline_n = 1'b0;
			res.compare_value = rem_ld[CMP_W-1:0] - 1'b1;
			rem_n = '0;
		end
		res.set_on_match  = mode_n;
		res.counter_reset = rline_n;
	end

	// fetch the entry for the index that holds after this cycle
	assign idx_d = ev ? idx_n : idx_q;

	always_comb begin
		tbl_req.wr_en   = fire && (cmd == CMD_WRITE);
		tbl_req.wr_idx  = {1'b0, channel};
		tbl_req.wr_data = pulse_ticks;
		tbl_req.rd_idx  = idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			mode_q  <= 1'b0;
			rline_q <= 1'b1;
		end else if (ev) begin
			rem_q   <= rem_n;
			sum_q   <= sum_n;
			idx_q   <= idx_n;
			mode_q  <= mode_n;
			rline_q <= rline_n;
		end
	end

endmodule

// File: rtl/servo_ppm_chunk_scheduler_unit.sv
// Servo PPM chunk scheduler: one result beat per compare event, none per table write.
// A compare event's result is on the output register in the cycle after acceptance.
// Throughput: one item per cycle while no result stalls; the next channel's pulse is
// prefetched from table memory, with forwarding of a write to the entry being fetched.
// Reset: asynchronous; table reads as zero, counter reset asserted, servo count 0,
// max pulse 5500. No clearing pass.
module servo_ppm_chunk_scheduler_unit import spcs_pkg::*; #(
	parameter int MAX_CHANNELS = 16
) (
	input logic         clk,
	input logic         arst_n,
	spcs_cfg_if.sink    cfg,
	spcs_item_if.sink   item,
	spcs_result_if.source result
);
	logic [IDX_W-1:0]  servo_count_q;
	logic [TICK_W-1:0] max_pulse_q;
	logic              res_valid_q;
	result_t           res_q;
	result_t           res;
	tbl_req_t          tbl_req;
	logic [TICK_W-1:0] next_pulse;
	logic              fire;

	assign cfg.ready  = 1'b1;
	assign item.ready = !res_valid_q || result.ready;
	assign fire       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_count_q <= '0;
			max_pulse_q   <= MAX_PULSE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SERVO_COUNT: servo_count_q <= cfg.data[IDX_W-1:0];
				REG_MAX_PULSE:   max_pulse_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	spcs_table #(.MAX_CHANNELS(MAX_CHANNELS)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (next_pulse)
	);

	spcs_sched u_sched (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.cmd             (item.cmd),
		.channel         (item.channel),
		.pulse_ticks     (item.pulse_ticks),
		.servo_count     (servo_count_q),
		.max_pulse_ticks (max_pulse_q),
		.next_pulse      (next_pulse),
		.tbl_req         (tbl_req),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item.ready) begin
			res_valid_q <= fire && (item.cmd == CMD_MATCH);
		end
	end

	// hold the payload until the beat is taken
	always_ff @(posedge clk) begin
		if (fire && (item.cmd == CMD_MATCH)) begin
			res_q <= res;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.compare_value = res_q.compare_value;
	assign result.set_on_match  = res_q.set_on_match;
	assign result.counter_reset = res_q.counter_reset;

endmodule

// File: rtl/spcs_checker.sv
// Port-level checks of the servo PPM chunk scheduler, bound to the top level.
module spcs_checker import spcs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       item_cmd,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_compare_value,
	input logic       res_counter_reset
);
	logic item_fire;
	assign item_fire = item_valid && item_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_match_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && (item_cmd == CMD_MATCH) |=> res_valid)
		else $error("compare event produced no result");

	a_write_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && (item_cmd == CMD_WRITE) && !res_valid |=> !res_valid)
		else $error("table write produced a result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> res_valid)
		else $error("input stalled with no pending result");

	a_reset_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_counter_reset |->
			(res_compare_value == CMP_LONG) || (res_compare_value == CMP_MID))
		else $error("final chunk with counter reset still asserted");

endmodule

bind servo_ppm_chunk_scheduler_unit spcs_checker u_spcs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_cmd          (item.cmd),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.res_compare_value (result.compare_value),
	.res_counter_reset (result.counter_reset)
);

// File: bench/spcs_frame_checker.sv
// Checker for the servo PPM chunk scheduler: predicts every chunk beat and compares it.
module spcs_frame_checker import spcs_pkg::*; #(
	parameter int MAX_CHANNELS = 16
) (
	input logic    clk,
	input logic    arst_n,
	spcs_cfg_if    cfg,
	spcs_item_if   item,
	spcs_result_if result,
	output int     mismatches,
	output int     chunks_owed
);

	logic [IDX_W-1:0]  servo_cnt;
	logic [TICK_W-1:0] max_pulse;
	logic [TICK_W-1:0] remain;
	logic [IDX_W-1:0]  chan_idx;
	logic [TICK_W-1:0] psum;
	logic [TICK_W-1:0] pulse_tbl [2**CHAN_W];
	logic              mode;
	logic              rline;
	result_t           chunk_due [$];

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Work out the next chunk of the frame from one compare event.
	task automatic schedule_chunk(output result_t chunk);
		logic [31:0] frame;
		if (remain == '0) begin
			if (chan_idx < servo_cnt) begin
				remain = (chan_idx < MAX_CHANNELS) ? pulse_tbl[chan_idx[CHAN_W-1:0]] : '0;
				psum = psum + remain;
				chan_idx = chan_idx + 1'b1;
			end else begin
				// frame gap: whatever is left of the frame after the pulses, 16-bit wrap
				frame = 32'(max_pulse) * 32'(servo_cnt) + 32'(FRAME_SLACK);
				remain = frame[TICK_W-1:0] - psum;
				psum = '0;
				chan_idx = '0;
				rline = 1'b1;
			end
		end
		if (remain > CHUNK_LONG_LIMIT) begin
			chunk.compare_value = CMP_LONG;
			mode = 1'b0;
			remain = remain - CHUNK_LONG;
		end else if (remain > CHUNK_MID_LIMIT) begin
			chunk.compare_value = CMP_MID;
			remain = remain - CHUNK_MID;
		end else begin
			// whole remainder; an empty one wraps to 255
			chunk.compare_value = remain[CMP_W-1:0] - 1'b1;
			mode = 1'b1;
			remain = '0;
			rline = 1'b0;
		end
		chunk.set_on_match = mode;
		chunk.counter_reset = rline;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			servo_cnt = '0;
			max_pulse = MAX_PULSE_RST;
			remain = '0;
			chan_idx = '0;
			psum = '0;
			for (int i = 0; i < 2**CHAN_W; i++)
				pulse_tbl[i] = '0;
			mode = 1'b0;
			rline = 1'b1;
			chunk_due.delete();
		end else begin
			// retire the beat leaving first; a beat accepted now cannot answer this edge
			if (result.valid && result.ready) begin
				if (chunk_due.size() == 0) begin
					$error("result beat with no chunk outstanding");
					mismatches++;
				end else begin
					want = chunk_due.pop_front();
					check_field("compare_value", want.compare_value, result.compare_value);
					check_field("set_on_match", want.set_on_match, result.set_on_match);
					check_field("counter_reset", want.counter_reset, result.counter_reset);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SERVO_COUNT)
					servo_cnt = cfg.data[IDX_W-1:0];
				else if (cfg.index == REG_MAX_PULSE)
					max_pulse = cfg.data;
			end
			if (item.valid && item.ready) begin
				if (item.cmd == CMD_WRITE) begin
					pulse_tbl[item.channel] = item.pulse_ticks;
				end else begin
					schedule_chunk(want);
					chunk_due.push_back(want);
				end
			end
		end
		chunks_owed = chunk_due.size();
	end

endmodule

// File: bench/tb_servo_ppm_chunk_scheduler_unit.sv
// Top of the servo PPM chunk scheduler bench: clock, reset, stimulus and verdict.
module tb_servo_ppm_chunk_scheduler_unit import spcs_pkg::*;;

	localparam int MAX_CH = 16;
	// indexes the block has no register behind
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	bit   squeeze;
	bit   squeezed;
	int   mismatches;
	int   chunks_owed;

	spcs_cfg_if    cfg_ch ();
	spcs_item_if   item_ch ();
	spcs_result_if res_ch ();

	servo_ppm_chunk_scheduler_unit #(.MAX_CHANNELS(MAX_CH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	spcs_frame_checker #(.MAX_CHANNELS(MAX_CH)) frame_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.item        (item_ch),
		.result      (res_ch),
		.mismatches  (mismatches),
		.chunks_owed (chunks_owed)
	);

	always #5 clk = ~clk;

	initial begin
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off to fill the block.
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze && !squeezed) begin
				res_ch.ready <= 1'b0;
				squeezed = 1'b1;
				repeat (120) @(negedge clk);
			end
			res_ch.ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	task automatic send_item(input logic op, input logic [CHAN_W-1:0] ch,
			input logic [TICK_W-1:0] len);
		while (!calm && $urandom_range(99) < 35) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= op;
		item_ch.channel <= ch;
		item_ch.pulse_ticks <= len;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly compare events; writes favour short pulses so frames turn over.
	task automatic send_random();
		logic [TICK_W-1:0] len;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 25) begin
			roll = $urandom_range(9);
			if (roll < 6)
				len = TICK_W'($urandom_range(700));
			else if (roll < 9)
				len = TICK_W'($urandom_range(400, 250));
			else
				len = TICK_W'($urandom);
			send_item(CMD_WRITE, CHAN_W'($urandom), len);
		end else begin
			send_item(CMD_MATCH, CHAN_W'($urandom), TICK_W'($urandom));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop the input and wait for every owed chunk to drain.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (chunks_owed != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reconfigure(input int servos, input int pulse, input bit spare);
		settle();
		write_reg(REG_SERVO_COUNT, 16'(servos));
		write_reg(REG_MAX_PULSE, 16'(pulse));
		if (spare) begin
			write_reg(REG_SPARE_2, 16'($urandom));
			write_reg(REG_SPARE_3, 16'($urandom));
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.cmd <= CMD_MATCH;
		item_ch.channel <= '0;
		item_ch.pulse_ticks <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_SERVO_COUNT;
		cfg_ch.data <= '0;
		calm = 1'b0;
		squeeze = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// table extremes and chunk boundaries; no channels yet, so frames are gap only
		send_item(CMD_WRITE, 4'd0, 16'd0);
		send_item(CMD_WRITE, 4'd1, 16'hFFFF);
		send_item(CMD_WRITE, 4'd2, 16'd385);
		send_item(CMD_WRITE, 4'd3, 16'd384);
		send_item(CMD_WRITE, 4'd4, 16'd257);
		send_item(CMD_WRITE, 4'd5, 16'd256);
		send_item(CMD_WRITE, 4'd6, 16'd1);
		send_item(CMD_WRITE, 4'd14, 16'h5555);
		send_item(CMD_WRITE, 4'd15, 16'hAAAA);
		repeat (3) send_item(CMD_MATCH, 4'd0, 16'd0);
		repeat (40) send_random();

		// one full frame: empty pulse, medium split, long split, then the gap
		reconfigure(3, 500, 1'b0);
		send_item(CMD_WRITE, 4'd0, 16'd0);
		send_item(CMD_WRITE, 4'd1, 16'd300);
		send_item(CMD_WRITE, 4'd2, 16'd385);
		repeat (9) send_item(CMD_MATCH, 4'd0, 16'd0);
		repeat (70) send_random();

		reconfigure(16, 400, 1'b0);
		calm = 1'b1;
		repeat (75) send_random();
		calm = 1'b0;

		// channels past the table read as zero
		reconfigure(31, 65535, 1'b1);
		repeat (75) send_random();

		reconfigure(1, 1, 1'b0);
		repeat (75) send_random();

		reconfigure(5, 600, 1'b0);
		squeeze = 1'b1;
		repeat (75) send_random();

		reconfigure(16, 0, 1'b0);
		repeat (75) send_random();

		reconfigure(0, 0, 1'b0);
		repeat (60) send_random();

		reconfigure(2, 450, 1'b0);
		repeat (75) send_random();

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
